// File: sv/vector2_fixed_alu_defines.svh
// Assertion macros for the vector2_fixed_alu checker.
// Depends on nothing; included by the checker file.
`ifndef VECTOR2_FIXED_ALU_DEFINES_SVH
`define VECTOR2_FIXED_ALU_DEFINES_SVH

// check a property on every edge outside reset
`define V2FA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define V2FA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/v2fa_pkg.sv
// Shared types and constants for the vector2_fixed_alu block.
// No dependencies.
`timescale 1ns / 1ps
package v2fa_pkg;

  localparam int DATA_W = 32;
  localparam int EPS_W  = 17;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_NEG    = 4'd2,
    OP_SCALE  = 4'd3,
    OP_MUL    = 4'd4,
    OP_DIVS   = 4'd5,
    OP_DIV    = 4'd6,
    OP_NORM   = 4'd7,
    OP_GETN   = 4'd8,
    OP_ISZERO = 4'd9,
    OP_ISNORM = 4'd10
  } op_e;

  typedef struct packed {
    logic [3:0]               op;
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic signed [DATA_W-1:0] bx;
    logic signed [DATA_W-1:0] by;
    logic signed [DATA_W-1:0] scale;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic                     test_true;
    logic                     guard_hit;
    logic                     saturated;
  } res_t;

endpackage

// File: sv/v2fa_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, 32 stages.
// Depends on nothing; used by vector2_fixed_alu for the magnitude.
`timescale 1ns / 1ps
module v2fa_sqrt_pipe (
  input  logic        clk_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  localparam int STAGES = 32;

  logic [63:0] vr_q   [STAGES];
  logic [33:0] rem_q  [STAGES];
  logic [31:0] root_q [STAGES];
  logic [63:0] vr_d   [STAGES];
  logic [33:0] rem_d  [STAGES];
  logic [31:0] root_d [STAGES];

  always_comb begin
    logic [63:0] vr_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] part;
    logic [35:0] trial;
    logic        ge;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        vr_in   = rad_i;
        rem_in  = '0;
        root_in = '0;
      end else begin
        vr_in   = vr_q[k-1];
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
      end
      part      = {rem_in, vr_in[63:62]};
      trial     = {2'b00, root_in, 2'b01};
      ge        = (part >= trial);
      rem_d[k]  = ge ? 34'(part - trial) : part[33:0];
      root_d[k] = {root_in[30:0], ge};
      vr_d[k]   = {vr_in[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < STAGES; k++) begin
      vr_q[k]   <= vr_d[k];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
    end
  end

  assign root_o = root_q[STAGES-1];

endmodule

// File: sv/v2fa_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing; used twice by vector2_fixed_alu.
`timescale 1ns / 1ps
module v2fa_div_pipe #(
  parameter int NUM_W = 48
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [31:0]      den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [31:0]      rem_q [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [31:0]      den_q [NUM_W];
  logic [31:0]      rem_d [NUM_W];
  logic [NUM_W-1:0] nq_d  [NUM_W];
  logic [31:0]      den_d [NUM_W];

  always_comb begin
    logic [31:0]      rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [31:0]      den_in;
    logic [32:0]      part;
    logic             ge;
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        rem_in = '0;
        nq_in  = num_i;
        den_in = den_i;
      end else begin
        rem_in = rem_q[k-1];
        nq_in  = nq_q[k-1];
        den_in = den_q[k-1];
      end
      part     = {rem_in, nq_in[NUM_W-1]};
      ge       = (part >= {1'b0, den_in});
      rem_d[k] = ge ? 32'(part - {1'b0, den_in}) : part[31:0];
      nq_d[k]  = {nq_in[NUM_W-2:0], ge};
      den_d[k] = den_in;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_W; k++) begin
      rem_q[k] <= rem_d[k];
      nq_q[k]  <= nq_d[k];
      den_q[k] <= den_d[k];
    end
  end

  assign quo_o = nq_q[NUM_W-1];

endmodule

// File: sv/vector2_fixed_alu.sv
// Two-component fixed-point vector ALU, top level.
// Depends on v2fa_pkg, v2fa_sqrt_pipe and v2fa_div_pipe.
// Fully pipelined: one item per cycle, busy_o never rises and cfg_ready_o is always high.
// Every item, whatever its op, passes through the 32-stage magnitude root followed by the
// 32 + FRAC_BITS stage divider; FRAC_BITS is 16 for the default Q16.16 format.
// Results appear on result_o for one cycle with done_o; the receiver cannot stall them.
// Write epsilon only while no item is in flight.
`timescale 1ns / 1ps
module vector2_fixed_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  v2fa_pkg::item_t item_i,
  output logic            done_o,
  output v2fa_pkg::res_t  result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [16:0]     cfg_data_i
);
  import v2fa_pkg::*;

  localparam int NUM_W   = DATA_W + FRAC_BITS;
  localparam int SQ_LAT  = 32;
  localparam int DIV_LAT = NUM_W;

  typedef struct packed {
    logic [3:0]               op;
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic [DATA_W-1:0]        axm;
    logic [DATA_W-1:0]        aym;
    logic [DATA_W-1:0]        dx;
    logic [DATA_W-1:0]        dy;
    logic                     negx;
    logic                     negy;
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic                     test;
    logic                     guard;
    logic                     sat;
    logic                     div_en;
  } side_t;

  function automatic logic [DATA_W:0] sat_sum(input logic [DATA_W:0] v);
    if (v[DATA_W] != v[DATA_W-1]) begin
      return {1'b1, v[DATA_W] ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return {1'b0, v[DATA_W-1:0]};
  endfunction

  function automatic logic [DATA_W:0] sat_prod(input logic signed [63:0] v);
    if (!((&v[63:31]) || !(|v[63:31]))) begin
      return {1'b1, v[63] ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [DATA_W:0] sat_quo(input logic [NUM_W-1:0] q, input logic neg);
    logic big;
    big = |q[NUM_W-1:DATA_W];
    if (neg) begin
      if (big || (q[31:0] > 32'h8000_0000)) begin
        return {1'b1, 32'h8000_0000};
      end
      return {1'b0, 32'(-q[31:0])};
    end
    if (big || q[31]) begin
      return {1'b1, 32'h7fff_ffff};
    end
    return {1'b0, q[31:0]};
  endfunction

  logic [EPS_W-1:0]  eps_q;
  logic [DATA_W-1:0] eps32;
  logic [63:0]       eps64;

  assign eps32       = DATA_W'(eps_q);
  assign eps64       = 64'(eps_q);
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 17'd1;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  // valid bits
  logic               v1_q, v2_q, v3_q, v4_q, done_q;
  logic [SQ_LAT-1:0]  vsq_q;
  logic [DIV_LAT-1:0] vdv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vsq_q  <= '0;
      v4_q   <= 1'b0;
      vdv_q  <= '0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      vsq_q  <= {vsq_q[SQ_LAT-2:0], v3_q};
      v4_q   <= vsq_q[SQ_LAT-1];
      vdv_q  <= {vdv_q[DIV_LAT-2:0], v4_q};
      done_q <= vdv_q[DIV_LAT-1];
    end
  end

  // stage 1
  item_t it_q;
  always_ff @(posedge clk_i) begin
    it_q <= item_i;
  end

  // stage 2: products, squares, sums, differences and negations, scalar and componentwise divisors
  side_t                    side2_d, side2_q;
  logic signed [63:0]       px_d, py_d, px_q, py_q;
  logic [63:0]              sqx_d, sqy_d, sqx_q, sqy_q;
  logic signed [DATA_W-1:0] mx, my;
  logic [DATA_W-1:0]        absx, absy, absbx, absby, abss;
  logic [DATA_W:0]          rsx, rsy;

  always_comb begin
    absx  = it_q.ax[31] ? 32'(-it_q.ax) : it_q.ax;
    absy  = it_q.ay[31] ? 32'(-it_q.ay) : it_q.ay;
    absbx = it_q.bx[31] ? 32'(-it_q.bx) : it_q.bx;
    absby = it_q.by[31] ? 32'(-it_q.by) : it_q.by;
    abss  = it_q.scale[31] ? 32'(-it_q.scale) : it_q.scale;
    mx    = (it_q.op == OP_SCALE) ? it_q.scale : it_q.bx;
    my    = (it_q.op == OP_SCALE) ? it_q.scale : it_q.by;
    px_d  = $signed(it_q.ax) * $signed(mx);
    py_d  = $signed(it_q.ay) * $signed(my);
    sqx_d = absx * absx;
    sqy_d = absy * absy;
    rsx   = '0;
    rsy   = '0;
    side2_d      = '0;
    side2_d.op   = it_q.op;
    side2_d.ax   = it_q.ax;
    side2_d.ay   = it_q.ay;
    side2_d.axm  = absx;
    side2_d.aym  = absy;
    case (it_q.op)
      OP_ADD: begin
        rsx = sat_sum({it_q.ax[31], it_q.ax} + {it_q.bx[31], it_q.bx});
        rsy = sat_sum({it_q.ay[31], it_q.ay} + {it_q.by[31], it_q.by});
      end
      OP_SUB: begin
        rsx = sat_sum({it_q.ax[31], it_q.ax} - {it_q.bx[31], it_q.bx});
        rsy = sat_sum({it_q.ay[31], it_q.ay} - {it_q.by[31], it_q.by});
      end
      OP_NEG: begin
        rsx = sat_sum(33'd0 - {it_q.ax[31], it_q.ax});
        rsy = sat_sum(33'd0 - {it_q.ay[31], it_q.ay});
      end
      OP_DIVS: begin
        side2_d.dx     = abss;
        side2_d.dy     = abss;
        side2_d.guard  = (abss <= eps32);
        side2_d.negx   = it_q.ax[31] ^ it_q.scale[31];
        side2_d.negy   = it_q.ay[31] ^ it_q.scale[31];
        side2_d.div_en = !(abss <= eps32);
      end
      OP_DIV: begin
        side2_d.dx     = absbx;
        side2_d.dy     = absby;
        side2_d.guard  = (absbx <= eps32) || (absby <= eps32);
        side2_d.negx   = it_q.ax[31] ^ it_q.bx[31];
        side2_d.negy   = it_q.ay[31] ^ it_q.by[31];
        side2_d.div_en = !((absbx <= eps32) || (absby <= eps32));
      end
      default: begin
      end
    endcase
    side2_d.rx  = rsx[DATA_W-1:0];
    side2_d.ry  = rsy[DATA_W-1:0];
    side2_d.sat = rsx[DATA_W] | rsy[DATA_W];
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
    px_q    <= px_d;
    py_q    <= py_d;
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
  end

  // stage 3: product shift and clamp, sum of squares
  side_t              side3_d, side3_q;
  logic [63:0]        sum_q;
  logic signed [63:0] pxs, pys;
  logic [DATA_W:0]    rpx, rpy;

  always_comb begin
    pxs     = px_q >>> FRAC_BITS;
    pys     = py_q >>> FRAC_BITS;
    rpx     = sat_prod(pxs);
    rpy     = sat_prod(pys);
    side3_d = side2_q;
    if ((side2_q.op == OP_SCALE) || (side2_q.op == OP_MUL)) begin
      side3_d.rx  = rpx[DATA_W-1:0];
      side3_d.ry  = rpy[DATA_W-1:0];
      side3_d.sat = rpx[DATA_W] | rpy[DATA_W];
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
    sum_q   <= sqx_q + sqy_q;
  end

  // magnitude stages: tests enter with the item, root comes out at the end
  side_t       sq_in;
  side_t       sq_q [SQ_LAT];
  logic [63:0] msq;
  logic [63:0] one64;
  logic [31:0] mag;

  assign one64 = 64'(1) << FRAC_BITS;

  always_comb begin
    msq   = sum_q >> FRAC_BITS;
    sq_in = side3_q;
    if (side3_q.op == OP_ISZERO) begin
      sq_in.test = (msq <= eps64);
    end else if (side3_q.op == OP_ISNORM) begin
      sq_in.test = (msq >= one64) ? ((msq - one64) <= eps64) : ((one64 - msq) <= eps64);
    end
  end

  v2fa_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sum_q),
    .root_o (mag)
  );

  always_ff @(posedge clk_i) begin
    sq_q[0] <= sq_in;
    for (int k = 1; k < SQ_LAT; k++) begin
      sq_q[k] <= sq_q[k-1];
    end
  end

  // stage 4: normalise divisor or short-vector guard
  side_t side4_d, side4_q;

  always_comb begin
    side4_d = sq_q[SQ_LAT-1];
    if ((side4_d.op == OP_NORM) || (side4_d.op == OP_GETN)) begin
      if (mag <= eps32) begin
        side4_d.guard = 1'b1;
        if (side4_d.op == OP_NORM) begin
          side4_d.rx = side4_d.ax;
          side4_d.ry = side4_d.ay;
        end
      end else begin
        side4_d.dx     = mag;
        side4_d.dy     = mag;
        side4_d.negx   = side4_d.ax[31];
        side4_d.negy   = side4_d.ay[31];
        side4_d.div_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side4_q <= side4_d;
  end

  // divider stages
  side_t            dv_q [DIV_LAT];
  logic [NUM_W-1:0] qx, qy;

  v2fa_div_pipe #(.NUM_W(NUM_W)) u_div_x (
    .clk_i (clk_i),
    .num_i ({side4_q.axm, FRAC_BITS'(0)}),
    .den_i (side4_q.dx),
    .quo_o (qx)
  );

  v2fa_div_pipe #(.NUM_W(NUM_W)) u_div_y (
    .clk_i (clk_i),
    .num_i ({side4_q.aym, FRAC_BITS'(0)}),
    .den_i (side4_q.dy),
    .quo_o (qy)
  );

  always_ff @(posedge clk_i) begin
    dv_q[0] <= side4_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      dv_q[k] <= dv_q[k-1];
    end
  end

  // output stage
  side_t           fin;
  logic [DATA_W:0] fqx, fqy;
  res_t            result_d, result_q;

  always_comb begin
    fin                = dv_q[DIV_LAT-1];
    fqx                = sat_quo(qx, fin.negx);
    fqy                = sat_quo(qy, fin.negy);
    result_d.rx        = fin.rx;
    result_d.ry        = fin.ry;
    result_d.test_true = fin.test;
    result_d.guard_hit = fin.guard;
    result_d.saturated = fin.sat;
    if (fin.div_en) begin
      result_d.rx        = fqx[DATA_W-1:0];
      result_d.ry        = fqy[DATA_W-1:0];
      result_d.saturated = fqx[DATA_W] | fqy[DATA_W];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// File: sv/v2fa_checker.sv
// Port-level checker for vector2_fixed_alu, attached by bind.
// Depends on v2fa_pkg and vector2_fixed_alu_defines.svh.
`timescale 1ns / 1ps
`include "vector2_fixed_alu_defines.svh"
module v2fa_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic            done_o,
  input v2fa_pkg::res_t  result_o,
  input logic            cfg_ready_o
);
  import v2fa_pkg::*;

  localparam int LAT = 69 + FRAC_BITS;

  `V2FA_ASSERT_IMP(a_done_latency, clk_i, rst_ni, done_o, $past(start_i && !busy_o, LAT), "result without item at fixed latency")
  `V2FA_ASSERT_IMP(a_test_zero, clk_i, rst_ni, done_o && result_o.test_true, (result_o.rx == 0) && (result_o.ry == 0), "test result with nonzero vector")
  `V2FA_ASSERT_IMP(a_guard_nosat, clk_i, rst_ni, done_o && result_o.guard_hit, !result_o.saturated && !result_o.test_true, "guard with clamp or test")
  `V2FA_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o && cfg_ready_o, "pipeline refused an item or write")

endmodule

bind vector2_fixed_alu v2fa_checker #(.FRAC_BITS(FRAC_BITS)) u_v2fa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .result_o    (result_o),
  .cfg_ready_o (cfg_ready_o)
);

// File: test/tb_top.sv
// Self-checking testbench for vector2_fixed_alu: directed and random vector operations
// under several epsilon settings, each result checked against an in-bench predictor.
// Depends on v2fa_pkg and the vector2_fixed_alu RTL.
`timescale 1ns / 1ps

class alu_scoreboard;
  v2fa_pkg::res_t pending[$];
  bit [16:0] eps;
  int errors;
  int seen;

  function longint clamp32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function longint fx_mul(longint a, longint b, ref bit sat);
    return clamp32(a * b >>> 16, sat);
  endfunction

  function longint fx_div(longint a, longint d, ref bit sat);
    return clamp32((a * 65536) / d, sat);
  endfunction

  function longint magabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function longint root(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function void note_item(v2fa_pkg::item_t it);
    longint ax, ay, bx, by, sc, e, rx, ry, m;
    bit [63:0] sq;
    bit t, g, s;
    v2fa_pkg::res_t r;
    ax = it.ax; ay = it.ay; bx = it.bx; by = it.by; sc = it.scale;
    e = eps;
    rx = 0; ry = 0; t = 0; g = 0; s = 0;
    sq = 64'(magabs(ax) * magabs(ax)) + 64'(magabs(ay) * magabs(ay));
    case (it.op)
      v2fa_pkg::OP_ADD: begin
        rx = clamp32(ax + bx, s); ry = clamp32(ay + by, s);
      end
      v2fa_pkg::OP_SUB: begin
        rx = clamp32(ax - bx, s); ry = clamp32(ay - by, s);
      end
      v2fa_pkg::OP_NEG: begin
        rx = clamp32(-ax, s); ry = clamp32(-ay, s);
      end
      v2fa_pkg::OP_SCALE: begin
        rx = fx_mul(ax, sc, s); ry = fx_mul(ay, sc, s);
      end
      v2fa_pkg::OP_MUL: begin
        rx = fx_mul(ax, bx, s); ry = fx_mul(ay, by, s);
      end
      v2fa_pkg::OP_DIVS: begin
        if (magabs(sc) <= e) g = 1;
        else begin
          rx = fx_div(ax, sc, s); ry = fx_div(ay, sc, s);
        end
      end
      v2fa_pkg::OP_DIV: begin
        if (magabs(bx) <= e || magabs(by) <= e) g = 1;
        else begin
          rx = fx_div(ax, bx, s); ry = fx_div(ay, by, s);
        end
      end
      v2fa_pkg::OP_NORM, v2fa_pkg::OP_GETN: begin
        m = root(sq);
        if (m > e) begin
          rx = fx_div(ax, m, s); ry = fx_div(ay, m, s);
        end else begin
          g = 1;
          if (it.op == v2fa_pkg::OP_NORM) begin
            rx = ax; ry = ay;
          end
        end
      end
      v2fa_pkg::OP_ISZERO: t = longint'(sq >> 16) <= e;
      v2fa_pkg::OP_ISNORM: t = magabs(longint'(sq >> 16) - 65536) <= e;
      default: ;
    endcase
    r.rx = rx[31:0]; r.ry = ry[31:0];
    r.test_true = t; r.guard_hit = g; r.saturated = s;
    pending.push_back(r);
  endfunction

  function void check_result(v2fa_pkg::res_t got);
    v2fa_pkg::res_t w;
    seen++;
    if (pending.size() == 0) begin
      $error("result with nothing expected");
      errors++;
      return;
    end
    w = pending.pop_front();
    if (got.rx !== w.rx) begin
      $error("rx expected %h actual %h", w.rx, got.rx); errors++;
    end
    if (got.ry !== w.ry) begin
      $error("ry expected %h actual %h", w.ry, got.ry); errors++;
    end
    if (got.test_true !== w.test_true) begin
      $error("test_true expected %b actual %b", w.test_true, got.test_true); errors++;
    end
    if (got.guard_hit !== w.guard_hit) begin
      $error("guard_hit expected %b actual %b", w.guard_hit, got.guard_hit); errors++;
    end
    if (got.saturated !== w.saturated) begin
      $error("saturated expected %b actual %b", w.saturated, got.saturated); errors++;
    end
  endfunction
endclass

module tb_top;
  import v2fa_pkg::*;

  localparam int LATENCY = 85;
  localparam int WATCHDOG = 5000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic busy_o;
  item_t item_i = '0;
  logic done_o;
  res_t result_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [16:0] cfg_data_i = '0;

  alu_scoreboard board;
  int idle_cycles;
  int n_items;
  int n_cfg;

  vector2_fixed_alu uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (done_o) board.check_result(result_o);
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3: return 32'h0001_0000;
      4: return -32'sh0001_0000;
      5: return 32'($signed($urandom_range(0, 131072)) - 65536);
      6: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  // drop start for a random number of cycles
  task automatic gap();
    int n;
    n = $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold the item until it is taken
  task automatic send(item_t it);
    start_i <= 1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_item(it);
    n_items++;
    if ($urandom_range(0, 2) == 0) begin
      gap();
    end
  endtask

  task automatic drain();
    start_i <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_eps(logic [16:0] v);
    drain();
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.eps = v;
    n_cfg++;
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_op(logic [3:0] op, logic [31:0] ax, logic [31:0] ay,
                         logic [31:0] bx, logic [31:0] by, logic [31:0] sc);
    item_t it;
    it.op = op; it.ax = ax; it.ay = ay; it.bx = bx; it.by = by; it.scale = sc;
    send(it);
  endtask

  task automatic random_items(int count);
    item_t it;
    repeat (count) begin
      it.op = $urandom_range(0, 11) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      it.ax = pick_val(); it.ay = pick_val(); it.bx = pick_val();
      it.by = pick_val(); it.scale = pick_val();
      send(it);
    end
  endtask

  initial begin
    board = new();
    board.eps = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_op(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff, 0);
    send_op(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff, 0);
    send_op(OP_NEG, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_op(OP_SCALE, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 32'h8000_0000);
    send_op(OP_MUL, 32'h0003_0000, 32'hffff_ffff, 32'hffff_8000, 32'd1, 0);
    send_op(OP_DIVS, 32'h0001_0000, 32'd5, 0, 0, 32'hffff_ffff);
    send_op(OP_DIVS, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'd2);
    send_op(OP_DIV, 32'd7, 32'd7, 32'd1, 32'h0002_0000, 0);
    send_op(OP_DIV, 32'h8000_0000, 32'h0004_0000, 32'hffff_fffe, 32'h0002_0000, 0);
    send_op(OP_NORM, 32'd1, 32'd0, 0, 0, 0);
    send_op(OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_op(OP_GETN, 32'd0, 32'd1, 0, 0, 0);
    send_op(OP_GETN, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0);
    send_op(OP_ISZERO, 32'd0, 32'd0, 0, 0, 0);
    send_op(OP_ISZERO, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
    send_op(OP_ISNORM, 32'h0001_0000, 32'd0, 0, 0, 0);
    send_op(OP_ISNORM, 32'h0000_b505, 32'h0000_b505, 0, 0, 0);
    send_op(4'd11, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    send_op(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    random_items(400);
    write_eps(17'd0);
    random_items(350);
    write_eps(17'h1ffff);
    random_items(350);
    write_eps(17'd65536);
    random_items(350);
    write_eps(17'($urandom_range(2, 4096)));
    random_items(300);
    write_eps(17'($urandom));
    random_items(250);

    drain();
    $display("covered %0d items over %0d epsilon writes, %0d results checked",
             n_items, n_cfg, board.seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/v2fa_pkg.sv
sv/v2fa_sqrt_pipe.sv
sv/v2fa_div_pipe.sv
sv/vector2_fixed_alu.sv
sv/v2fa_checker.sv
test/tb_top.sv
